FILE: sv/multichannel_slew_limiter_macros.svh
// ----------------------------------------------------------------------------
// Slew limiter assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SLEW_LIMITER_MACROS_SVH
`define MULTICHANNEL_SLEW_LIMITER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SLR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/slr_pkg.sv
// ----------------------------------------------------------------------------
// Slew limiter package
// Request types, table entry layout, operation and register codes.
// ----------------------------------------------------------------------------
package slr_pkg;

	localparam int SPEED_W = 8;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_SET     = 3'd1,
		OP_BYPASS  = 3'd2,
		OP_DISABLE = 3'd3,
		OP_ENABLE  = 3'd4,
		OP_TICK    = 3'd5
	} slr_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TABLE,
		ST_TICK
	} slr_state_t;

	localparam logic CFG_MAX_SPEED = 1'b0;
	localparam logic CFG_MIN_SPEED = 1'b1;

	localparam logic signed [SPEED_W-1:0] MAX_SPEED_RST = 8'sd127;
	localparam logic signed [SPEED_W-1:0] MIN_SPEED_RST = -8'sd127;

	typedef struct packed {
		logic [2:0]                operation;
		logic [2:0]                channel;
		logic signed [SPEED_W-1:0] value;
	} slr_in_t;

	typedef struct packed {
		logic [2:0]                out_channel;
		logic signed [SPEED_W-1:0] drive;
		logic                      last;
	} slr_out_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] req;
		logic signed [SPEED_W-1:0] cur;
		logic signed [SPEED_W-1:0] step;
		logic                      en;
	} slr_entry_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] max_speed;
		logic signed [SPEED_W-1:0] min_speed;
	} slr_limits_t;

endpackage

FILE: sv/multichannel_slew_limiter.sv
// ----------------------------------------------------------------------------
// Multichannel slew-rate limiter
// Channel table with per-channel slew stepping and a walking drive tick.
// ----------------------------------------------------------------------------
// The block keeps a table of CHANNELS channels (request, current speed, slew
// step, enable) in one synchronous memory with one read and one write port.
// A table request (add, set, bypass, disable, enable) reads the entry in the
// accept cycle and writes the modified entry back in the next. Requests with
// an unused operation code or a channel at or above CHANNELS are accepted and
// change nothing. A tick request reads one channel per cycle while the result
// side does not stall; meanwhile the previous channel is slewed, written back
// if enabled and loaded into the result register, so a tick returns CHANNELS
// results. New requests are held off for the whole tick and table update.
// Configuration writes (max_speed, min_speed) take effect at the next slew
// step; write them only while the block is idle. The max clamp is applied
// before the min clamp, so min_speed wins when the two cross.
// ----------------------------------------------------------------------------
`include "multichannel_slew_limiter_macros.svh"

module multichannel_slew_limiter #(
	parameter int CHANNELS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// request side
	input  logic                in_valid,
	output logic                in_stall,
	input  slr_pkg::slr_in_t    in_request,
	// result side
	output logic                out_valid,
	input  logic                out_stall,
	output slr_pkg::slr_out_t   out_request,
	// configuration
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic signed [slr_pkg::SPEED_W-1:0] cfg_wdata
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);

	// FSM and walk state
	slr_pkg::slr_state_t state_q, state_d;
	logic [AW-1:0]       next_idx_q;
	logic                issued_all_q;
	logic                pend_s1;
	logic [AW-1:0]       pend_idx_s1;

	// captured table request
	logic [2:0]                         op_q;
	logic [AW-1:0]                      ch_q;
	logic signed [slr_pkg::SPEED_W-1:0] val_q;

	// configuration registers
	slr_pkg::slr_limits_t limits_q;

	// result register
	logic              out_valid_q;
	slr_pkg::slr_out_t out_q;

	// memory ports
	logic                rd_en, wr_en;
	logic [AW-1:0]       rd_addr, wr_addr;
	slr_pkg::slr_entry_t rd_data, wr_data;

	// decode and datapath
	logic                               in_accept;
	logic                               is_tick, table_ok;
	logic [31:0]                        ch_ext, pend_idx_ext;
	logic [AW-1:0]                      ch_addr;
	logic                               out_free, process, issue;
	logic signed [slr_pkg::SPEED_W-1:0] slewed;
	slr_pkg::slr_entry_t                table_entry, tick_entry;
	slr_pkg::slr_out_t                  result;

	assign in_accept = in_valid && !in_stall;
	assign is_tick   = (in_request.operation == slr_pkg::OP_TICK);
	assign ch_ext    = 32'(in_request.channel);
	assign ch_addr   = ch_ext[AW-1:0];
	assign table_ok  = (in_request.operation inside {slr_pkg::OP_ADD, slr_pkg::OP_SET,
		slr_pkg::OP_BYPASS, slr_pkg::OP_DISABLE, slr_pkg::OP_ENABLE})
		&& (ch_ext < 32'(CHANNELS));

	// The result register frees up when empty or being taken this cycle.
	assign out_free = !out_valid_q || !out_stall;

	slr_state_mem #(
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	slr_slew_unit u_slew (
		.cur    (rd_data.cur),
		.req    (rd_data.req),
		.step   (rd_data.step),
		.limits (limits_q),
		.slewed (slewed)
	);

	// Modify the read entry for a table request.
	always_comb begin
		table_entry = rd_data;
		case (op_q)
			slr_pkg::OP_ADD: begin
				table_entry.req  = '0;
				table_entry.cur  = '0;
				table_entry.step = val_q;
				table_entry.en   = 1'b1;
			end
			slr_pkg::OP_SET: begin
				table_entry.req = val_q;
			end
			slr_pkg::OP_BYPASS: begin
				table_entry.req = val_q;
				table_entry.cur = val_q;
			end
			slr_pkg::OP_DISABLE: begin
				table_entry.en = 1'b0;
			end
			slr_pkg::OP_ENABLE: begin
				table_entry.en = 1'b1;
			end
			default: begin
				table_entry = rd_data;
			end
		endcase
	end

	// Tick datapath: enabled channels store and drive the slewed speed,
	// disabled channels drive the raw request.
	always_comb begin
		tick_entry     = rd_data;
		tick_entry.cur = slewed;
	end

	assign pend_idx_ext       = 32'(pend_idx_s1);
	assign result.out_channel = pend_idx_ext[2:0];
	assign result.drive       = rd_data.en ? slewed : rd_data.req;
	assign result.last        = (pend_idx_s1 == LAST_IDX);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			slr_pkg::ST_IDLE: begin
				if (in_valid && is_tick) begin
					state_d = slr_pkg::ST_TICK;
				end else if (in_valid && table_ok) begin
					state_d = slr_pkg::ST_TABLE;
				end
			end
			slr_pkg::ST_TABLE: begin
				state_d = slr_pkg::ST_IDLE;
			end
			slr_pkg::ST_TICK: begin
				if (process && pend_idx_s1 == LAST_IDX) begin
					state_d = slr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slr_pkg::ST_IDLE;
			end
		endcase
	end

	// FSM outputs: memory ports, stall, walk strobes
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = next_idx_q;
		wr_en    = 1'b0;
		wr_addr  = pend_idx_s1;
		wr_data  = tick_entry;
		process  = 1'b0;
		issue    = 1'b0;
		case (state_q)
			slr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && is_tick) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end else if (in_valid && table_ok) begin
					rd_en   = 1'b1;
					rd_addr = ch_addr;
				end
			end
			slr_pkg::ST_TABLE: begin
				wr_en   = 1'b1;
				wr_addr = ch_q;
				wr_data = table_entry;
			end
			slr_pkg::ST_TICK: begin
				// Retire the pending channel when the result slot is free;
				// read the next channel into the slot it leaves.
				process = pend_s1 && out_free;
				issue   = !issued_all_q && (!pend_s1 || process);
				rd_en   = issue;
				wr_en   = process && rd_data.en;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= slr_pkg::ST_IDLE;
			next_idx_q   <= '0;
			issued_all_q <= 1'b0;
			pend_s1      <= 1'b0;
			pend_idx_s1  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == slr_pkg::ST_IDLE) begin
				if (in_valid && is_tick) begin
					// Channel zero is read in the accept cycle.
					pend_s1      <= 1'b1;
					pend_idx_s1  <= '0;
					next_idx_q   <= AW'(1);
					issued_all_q <= (CHANNELS == 1);
				end
			end else if (state_q == slr_pkg::ST_TICK) begin
				pend_s1 <= issue || (pend_s1 && !process);
				if (issue) begin
					pend_idx_s1  <= next_idx_q;
					next_idx_q   <= next_idx_q + AW'(1);
					issued_all_q <= (next_idx_q == LAST_IDX);
				end
			end
		end
	end

	// Capture the table request payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q  <= in_request.operation;
			ch_q  <= ch_addr;
			val_q <= in_request.value;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.max_speed <= slr_pkg::MAX_SPEED_RST;
			limits_q.min_speed <= slr_pkg::MIN_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slr_pkg::CFG_MAX_SPEED: limits_q.max_speed <= cfg_wdata;
				slr_pkg::CFG_MIN_SPEED: limits_q.min_speed <= cfg_wdata;
				default: limits_q <= limits_q;
			endcase
		end
	end

	// Result register: load on retire, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			out_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_request = out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`SLR_ASSERT_SAME(a_no_accept_mid_tick, in_valid && !in_stall, !pend_s1,
		"request accepted while a channel read is pending")
	`SLR_ASSERT_SAME(a_rw_distinct, rd_en && wr_en, rd_addr != wr_addr,
		"table read and write hit the same entry in one cycle")
	`SLR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_request), "stalled result changed or was dropped")
	`SLR_ASSERT_NEXT(a_retire_last_idle, process && pend_idx_s1 == LAST_IDX,
		state_q == slr_pkg::ST_IDLE && !pend_s1, "tick walk did not finish after last channel")

endmodule

FILE: sv/slr_state_mem.sv
// ----------------------------------------------------------------------------
// Slew limiter channel table
// One-read, one-write synchronous memory; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module slr_state_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output slr_pkg::slr_entry_t rd_data,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  slr_pkg::slr_entry_t wr_data
);

	slr_pkg::slr_entry_t mem [DEPTH];
	logic [DEPTH-1:0]    vld_q;
	slr_pkg::slr_entry_t rd_data_q;

	// Entry valid bits: cleared at reset, set on first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold read data until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= vld_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/slr_slew_unit.sv
// ----------------------------------------------------------------------------
// Slew limiter step unit
// Move current speed toward the request by one step, then clamp.
// ----------------------------------------------------------------------------
module slr_slew_unit (
	input  logic signed [slr_pkg::SPEED_W-1:0] cur,
	input  logic signed [slr_pkg::SPEED_W-1:0] req,
	input  logic signed [slr_pkg::SPEED_W-1:0] step,
	input  slr_pkg::slr_limits_t               limits,
	output logic signed [slr_pkg::SPEED_W-1:0] slewed
);

	// Two extra bits cover a full-width step in either direction.
	localparam int WW = slr_pkg::SPEED_W + 2;

	logic signed [WW-1:0] c0, r, s, mx, mn;
	logic signed [WW-1:0] up, c1, dn, c2, c3, c4;

	assign c0 = WW'(cur);
	assign r  = WW'(req);
	assign s  = WW'(step);
	assign mx = WW'(limits.max_speed);
	assign mn = WW'(limits.min_speed);

	always_comb begin
		// Below the request: add the step, stop at the request.
		up = c0 + s;
		if (c0 < r) begin
			c1 = (up > r) ? r : up;
		end else begin
			c1 = c0;
		end
		// Above the request: subtract the step, stop at the request.
		dn = c1 - s;
		if (c1 > r) begin
			c2 = (dn < r) ? r : dn;
		end else begin
			c2 = c1;
		end
		// Max clamp first, min clamp wins.
		c3 = (c2 > mx) ? mx : c2;
		c4 = (c3 < mn) ? mn : c3;
	end

	assign slewed = c4[slr_pkg::SPEED_W-1:0];

endmodule

FILE: dv/slr_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slew limiter drive checker
// Watches the request, result and configuration ports, keeps its own copy of
// the channel table and limits, and compares every result with the oldest
// predicted drive.
// ----------------------------------------------------------------------------
module slr_drive_checker #(
	parameter int CHANNELS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  slr_pkg::slr_in_t                    in_request,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  slr_pkg::slr_out_t                   out_request,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic signed [slr_pkg::SPEED_W-1:0]  cfg_wdata,
	output int                                  mismatches,
	output int                                  outstanding
);

	logic signed [slr_pkg::SPEED_W-1:0] req_tab  [CHANNELS];
	logic signed [slr_pkg::SPEED_W-1:0] cur_tab  [CHANNELS];
	logic signed [slr_pkg::SPEED_W-1:0] step_tab [CHANNELS];
	logic                               en_tab   [CHANNELS];
	logic signed [slr_pkg::SPEED_W-1:0] max_lim;
	logic signed [slr_pkg::SPEED_W-1:0] min_lim;
	slr_pkg::slr_out_t                  drive_q[$];
	int                                 err_count = 0;

	task automatic report_mismatch(input string what);
		err_count++;
		$display("[%0t] drive check: %s", $time, what);
	endtask

	// Full-width step toward the request, then max clamp, then min clamp.
	function automatic logic signed [slr_pkg::SPEED_W-1:0] slew_toward(
		input logic signed [slr_pkg::SPEED_W-1:0] cur8,
		input logic signed [slr_pkg::SPEED_W-1:0] req8,
		input logic signed [slr_pkg::SPEED_W-1:0] step8
	);
		int cur;
		int req;
		cur = cur8;
		req = req8;
		if (cur < req) begin
			cur = cur + step8;
			if (cur > req)
				cur = req;
		end
		if (cur > req) begin
			cur = cur - step8;
			if (cur < req)
				cur = req;
		end
		if (cur > max_lim)
			cur = max_lim;
		if (cur < min_lim)
			cur = min_lim;
		return cur[slr_pkg::SPEED_W-1:0];
	endfunction

	function automatic void apply_request(input slr_pkg::slr_in_t r);
		slr_pkg::slr_out_t e;
		if (r.operation == slr_pkg::OP_TICK) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (en_tab[i]) begin
					cur_tab[i] = slew_toward(cur_tab[i], req_tab[i], step_tab[i]);
					e.drive    = cur_tab[i];
				end else begin
					e.drive = req_tab[i];
				end
				e.out_channel = 3'(i);
				e.last        = (i == CHANNELS - 1);
				drive_q.push_back(e);
			end
		end else if (int'(r.channel) < CHANNELS) begin
			case (r.operation)
				slr_pkg::OP_ADD: begin
					req_tab[r.channel]  = '0;
					cur_tab[r.channel]  = '0;
					step_tab[r.channel] = r.value;
					en_tab[r.channel]   = 1'b1;
				end
				slr_pkg::OP_SET: begin
					req_tab[r.channel] = r.value;
				end
				slr_pkg::OP_BYPASS: begin
					req_tab[r.channel] = r.value;
					cur_tab[r.channel] = r.value;
				end
				slr_pkg::OP_DISABLE: begin
					en_tab[r.channel] = 1'b0;
				end
				slr_pkg::OP_ENABLE: begin
					en_tab[r.channel] = 1'b1;
				end
				default: begin
				end
			endcase
		end
	endfunction

	task automatic check_drive(input slr_pkg::slr_out_t got);
		slr_pkg::slr_out_t want;
		if (drive_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result channel %0d drive %0d last %0b",
				got.out_channel, got.drive, got.last));
		end else begin
			want = drive_q.pop_front();
			if (got.out_channel !== want.out_channel)
				report_mismatch($sformatf("out_channel %0d, expected %0d",
					got.out_channel, want.out_channel));
			if (got.drive !== want.drive)
				report_mismatch($sformatf("drive %0d on channel %0d, expected %0d",
					got.drive, want.out_channel, want.drive));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %0b on channel %0d, expected %0b",
					got.last, want.out_channel, want.last));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				req_tab[i]  = '0;
				cur_tab[i]  = '0;
				step_tab[i] = '0;
				en_tab[i]   = 1'b0;
			end
			max_lim = slr_pkg::MAX_SPEED_RST;
			min_lim = slr_pkg::MIN_SPEED_RST;
			drive_q.delete();
		end else begin
			if (out_valid && !out_stall)
				check_drive(out_request);
			if (cfg_we) begin
				if (cfg_index == slr_pkg::CFG_MAX_SPEED)
					max_lim = cfg_wdata;
				else
					min_lim = cfg_wdata;
			end
			if (in_valid && !in_stall)
				apply_request(in_request);
		end
		mismatches  <= err_count;
		outstanding <= drive_q.size();
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slew limiter testbench top
// Drives directed and random table and tick requests through several limit
// settings and idling patterns, including a long result-side hold-off, and
// gives the verdict from the drive checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CHANNELS       = 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = CHANNELS + 4;
	localparam int PHASE_ITEMS    = 56;

	// Operation codes the block must ignore.
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	slr_pkg::slr_in_t                   in_request;
	logic                               out_valid;
	logic                               out_stall;
	slr_pkg::slr_out_t                  out_request;
	logic                               cfg_we;
	logic                               cfg_index;
	logic signed [slr_pkg::SPEED_W-1:0] cfg_wdata;
	int                                 mismatches;
	int                                 outstanding;

	// Idle percentages of the two sides, and the hold-off request flag.
	int   sender_pct = 0;
	int   stall_pct  = 0;
	logic hold_go    = 1'b0;

	multichannel_slew_limiter #(
		.CHANNELS(CHANNELS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_request (in_request),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_request(out_request),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	slr_drive_checker #(
		.CHANNELS(CHANNELS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_request (in_request),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_request(out_request),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #10 clk = ~clk;

	// Watchdog: count cycles in which neither channel moves a request.
	initial begin
		int stalled_for;
		stalled_for = 0;
		while (stalled_for < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stalled_for = 0;
			else
				stalled_for++;
		end
		$display("** multichannel_slew_limiter: FAILED **");
		$finish;
	end

	// Result side: random stalls, or a long counted hold-off when asked for.
	initial begin
		int held;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				out_stall <= 1'b1;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(posedge clk);
					held++;
				end
				hold_go = 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	function automatic int idle_gap(input int pct);
		int g;
		g = 0;
		while (g < 40 && $urandom_range(0, 99) < pct)
			g++;
		return g;
	endfunction

	// Speeds: lean on the extremes and on values near zero.
	function automatic logic signed [slr_pkg::SPEED_W-1:0] rand_speed();
		case ($urandom_range(0, 7))
			0:       return 8'sd127;
			1:       return -8'sd128;
			2, 3:    return 8'($urandom_range(0, 20) - 10);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Slew steps: mostly small positive, some zero, negative and extreme.
	function automatic logic signed [slr_pkg::SPEED_W-1:0] rand_step();
		case ($urandom_range(0, 9))
			0:       return 8'sd0;
			1:       return 8'sd127;
			2:       return -8'sd128;
			3:       return 8'(-$urandom_range(1, 8));
			4:       return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic slr_pkg::slr_in_t random_request();
		slr_pkg::slr_in_t r;
		int               pick;
		pick        = $urandom_range(0, 99);
		r.channel   = 3'($urandom_range(0, CHANNELS - 1));
		r.value     = rand_speed();
		if (pick < 18) begin
			r.operation = slr_pkg::OP_TICK;
		end else if (pick < 30) begin
			r.operation = slr_pkg::OP_ADD;
			r.value     = rand_step();
		end else if (pick < 55) begin
			r.operation = slr_pkg::OP_SET;
		end else if (pick < 67) begin
			r.operation = slr_pkg::OP_BYPASS;
		end else if (pick < 77) begin
			r.operation = slr_pkg::OP_DISABLE;
		end else if (pick < 96) begin
			r.operation = slr_pkg::OP_ENABLE;
		end else begin
			r.operation = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
		end
		return r;
	endfunction

	// Offer one request, hold it until accepted, then maybe drop valid a while.
	task automatic send_request(input slr_pkg::slr_in_t r);
		int gap;
		in_request <= r;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = idle_gap(sender_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue(input logic [2:0] op, input int ch, input int v);
		slr_pkg::slr_in_t r;
		r.operation = op;
		r.channel   = 3'(ch);
		r.value     = 8'(v);
		send_request(r);
	endtask

	// Random items; ignored operation codes do not count toward the total.
	task automatic run_random(input int count);
		slr_pkg::slr_in_t r;
		int               done;
		done = 0;
		while (done < count) begin
			r = random_request();
			if (r.operation <= slr_pkg::OP_TICK)
				done++;
			send_request(r);
		end
	endtask

	// Drop valid, wait for every predicted drive, then let the block settle.
	task automatic quiesce();
		if (in_valid)
			in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_limits(input logic signed [slr_pkg::SPEED_W-1:0] upper,
		input logic signed [slr_pkg::SPEED_W-1:0] lower);
		cfg_we    <= 1'b1;
		cfg_index <= slr_pkg::CFG_MAX_SPEED;
		cfg_wdata <= upper;
		@(posedge clk);
		cfg_index <= slr_pkg::CFG_MIN_SPEED;
		cfg_wdata <= lower;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_request = '0;
		cfg_we     = 1'b0;
		cfg_index  = slr_pkg::CFG_MAX_SPEED;
		cfg_wdata  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset limits: first tick sees an all-disabled table.
		issue(slr_pkg::OP_TICK, 0, 0);
		// Extreme and negative steps, a zero step, extreme requests.
		issue(slr_pkg::OP_ADD, 0, 127);
		issue(slr_pkg::OP_ADD, 7, -128);
		issue(slr_pkg::OP_ADD, 3, 1);
		issue(slr_pkg::OP_ADD, 2, -3);
		issue(slr_pkg::OP_ADD, 1, 0);
		issue(slr_pkg::OP_SET, 0, 127);
		issue(slr_pkg::OP_SET, 7, -128);
		issue(slr_pkg::OP_SET, 3, -1);
		issue(slr_pkg::OP_SET, 2, 20);
		issue(slr_pkg::OP_SET, 1, 50);
		// Bypass on disabled channels: raw request goes out.
		issue(slr_pkg::OP_BYPASS, 5, -128);
		issue(slr_pkg::OP_BYPASS, 6, 127);
		// Tick with junk in the unused fields.
		issue(slr_pkg::OP_TICK, 7, -1);
		issue(slr_pkg::OP_TICK, 0, 0);
		// Disable with a junk value, move the request, then re-enable.
		issue(slr_pkg::OP_DISABLE, 3, 99);
		issue(slr_pkg::OP_SET, 3, -100);
		issue(slr_pkg::OP_TICK, 0, 0);
		issue(slr_pkg::OP_ENABLE, 3, -99);
		issue(slr_pkg::OP_TICK, 0, 0);
		// Unused operation codes change nothing.
		issue(OP_SPARE_LO, 4, 127);
		issue(OP_SPARE_HI, 4, -128);
		// Bypass an enabled channel below min_speed: the slew clamp pulls it up.
		issue(slr_pkg::OP_BYPASS, 0, -128);
		issue(slr_pkg::OP_TICK, 0, 0);
		quiesce();

		// Widest limits, no idling on either side.
		program_limits(8'sd127, -8'sd128);
		run_random(PHASE_ITEMS);
		quiesce();

		// Crossed extremes: min clamp wins. Sender mostly idle.
		sender_pct = 75;
		program_limits(-8'sd128, 8'sd127);
		run_random(PHASE_ITEMS);
		quiesce();

		// Narrow window, receiver mostly stalling.
		sender_pct = 0;
		stall_pct  = 75;
		program_limits(8'sd40, -8'sd40);
		run_random(PHASE_ITEMS);
		quiesce();

		// Random limits, both sides idling now and then.
		sender_pct = 34;
		stall_pct  = 34;
		program_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		run_random(PHASE_ITEMS);
		quiesce();

		// Back to reset limits; hold off the result side while ticks pile up
		// so the block backs up and stalls its request side.
		sender_pct = 0;
		stall_pct  = 0;
		program_limits(slr_pkg::MAX_SPEED_RST, slr_pkg::MIN_SPEED_RST);
		hold_go = 1'b1;
		repeat (12) issue(slr_pkg::OP_TICK, 0, 0);
		run_random(PHASE_ITEMS - 12);
		quiesce();

		if (mismatches == 0 && outstanding == 0)
			$display("** multichannel_slew_limiter: PASSED **");
		else
			$display("** multichannel_slew_limiter: FAILED **");
		$finish;
	end

endmodule
